/* hdl/kxs_pkg.sv */
// Shared types and constants for the rolling-key XOR scrambler.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package kxs_pkg;

    // Command codes carried in s_tuser
    localparam logic [1:0] CMD_TEXT  = 2'd0;
    localparam logic [1:0] CMD_BEGIN = 2'd1;
    localparam logic [1:0] CMD_MSG   = 2'd2;

    // Text store geometry: the address field spans the whole store
    localparam int TEXT_AW    = 10;
    localparam int TEXT_DEPTH = 1 << TEXT_AW;

    // Message position counter, saturates at all ones
    localparam int POS_W       = 14;
    localparam int MAX_MESSAGE = 1 << POS_W;

    // Character substitution
    localparam logic [7:0] CHAR_DOT     = 8'h2E;
    localparam logic [7:0] CHAR_PERCENT = 8'h25;

    // Configuration space
    localparam int          APB_AW        = 3;
    localparam logic        REG_CHALLENGE = 1'b0;

    // One input transaction, unpacked
    typedef struct packed {
        logic [1:0]         cmd;
        logic [TEXT_AW-1:0] text_addr;
        logic [7:0]         text_byte;
        logic [7:0]         key_seed;
        logic [POS_W-1:0]   start_pos;
        logic [7:0]         payload_byte;
    } item_t;

    // Control from the key unit to the text store
    typedef struct packed {
        logic               wr_en;
        logic [TEXT_AW-1:0] wr_addr;
        logic [7:0]         wr_data;
        logic               rewind;
        logic               advance;
    } txt_ctl_t;

endpackage

/* hdl/kxs_apb_regs.sv */
// APB configuration register: the challenge key.
// Depends on kxs_pkg.
`timescale 1ns / 1ps

module kxs_apb_regs (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kxs_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready,
    output logic [7:0]                 challenge
);
    import kxs_pkg::*;

    logic [7:0] challenge_reg;
    logic [7:0] challenge_next;
    logic       wr_hit;

    assign pready = 1'b1;

    // Decode a write to the challenge register
    assign wr_hit = psel && penable && pwrite && pready
                    && (paddr[APB_AW-1] == REG_CHALLENGE);

    always_comb
    begin
        challenge_next = challenge_reg;
        if (wr_hit)
        begin
            challenge_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            challenge_reg <= 8'd0;
        end
        else
        begin
            challenge_reg <= challenge_next;
        end
    end

    // Return the register value, zero elsewhere
    assign prdata    = (paddr[APB_AW-1] == REG_CHALLENGE) ? {24'd0, challenge_reg} : 32'd0;
    assign challenge = challenge_reg;

endmodule

/* hdl/kxs_text_store.sv */
// Command text memory with a prefetched character at the read index.
// Depends on kxs_pkg.
`timescale 1ns / 1ps

module kxs_text_store (
    input  logic              clk,
    input  logic              rst_n,
    input  kxs_pkg::txt_ctl_t ctl,
    output logic [7:0]        cur_char
);
    import kxs_pkg::*;

    logic [7:0]         mem [TEXT_DEPTH];
    logic [7:0]         pf_reg;
    logic [7:0]         text0_reg;
    logic [7:0]         text0_next;
    logic [TEXT_AW-1:0] idx_reg;
    logic [TEXT_AW-1:0] idx_next;
    logic [TEXT_AW-1:0] adv_base;
    logic [TEXT_AW-1:0] idx_inc;
    logic               at_nul;
    logic [7:0]         raw_char;

    // On a terminator the text restarts at entry 0, kept in a shadow copy
    assign at_nul   = (pf_reg == 8'd0);
    assign raw_char = at_nul ? text0_reg : pf_reg;
    assign cur_char = (raw_char[7] || raw_char == CHAR_PERCENT) ? CHAR_DOT : raw_char;

    // Advance the read index, wrapping at the store depth
    assign adv_base = at_nul ? '0 : idx_reg;
    assign idx_inc  = (adv_base == TEXT_AW'(TEXT_DEPTH - 1)) ? '0 : adv_base + 1'b1;

    always_comb
    begin
        idx_next = idx_reg;
        if (ctl.rewind)
        begin
            idx_next = '0;
        end
        else if (ctl.advance)
        begin
            idx_next = idx_inc;
        end
    end

    always_comb
    begin
        text0_next = text0_reg;
        if (ctl.wr_en && ctl.wr_addr == '0)
        begin
            text0_next = ctl.wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

    // Write the memory and refetch the next index every cycle, write-first
    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[ctl.wr_addr] <= ctl.wr_data;
        end
        if (ctl.wr_en && ctl.wr_addr == idx_next)
        begin
            pf_reg <= ctl.wr_data;
        end
        else
        begin
            pf_reg <= mem[idx_next];
        end
        text0_reg <= text0_next;
    end

endmodule

/* hdl/kxs_key_unit.sv */
// Rolling key, position tracking and result register.
// Depends on kxs_pkg; drives the text store through txt_ctl_t.
`timescale 1ns / 1ps

module kxs_key_unit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    input  kxs_pkg::item_t    item,
    output logic              item_ready,
    input  logic [7:0]        challenge,
    input  logic [7:0]        cur_char,
    output kxs_pkg::txt_ctl_t ctl,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [7:0]        out_byte,
    output logic              out_scr
);
    import kxs_pkg::*;

    logic [7:0]       key_reg;
    logic [7:0]       key_next;
    logic [POS_W-1:0] pos_reg;
    logic [POS_W-1:0] pos_next;
    logic [POS_W-1:0] start_reg;
    logic [POS_W-1:0] start_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    logic [7:0]       out_byte_reg;
    logic [7:0]       out_byte_next;
    logic             out_scr_reg;
    logic             out_scr_next;

    logic             is_msg;
    logic             take;
    logic             scr;
    logic [7:0]       shifted;
    logic [7:0]       key_rolled;

    // Hold a message byte while the result register is full and not taken
    assign is_msg     = (item.cmd == CMD_MSG);
    assign item_ready = !(is_msg && out_valid_reg && !out_ready);
    assign take       = item_valid && item_ready;

    assign scr        = (pos_reg >= start_reg);
    assign shifted    = pos_reg[0] ? {cur_char[6:0], 1'b0} : cur_char;
    assign key_rolled = key_reg ^ shifted;

    // Text store control
    always_comb
    begin
        ctl.wr_en   = take && (item.cmd == CMD_TEXT);
        ctl.wr_addr = item.text_addr;
        ctl.wr_data = item.text_byte;
        ctl.rewind  = take && (item.cmd == CMD_BEGIN);
        ctl.advance = take && is_msg && scr;
    end

    // Update key, start and position
    always_comb
    begin
        key_next   = key_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        if (take)
        begin
            case (item.cmd)
                CMD_BEGIN:
                begin
                    key_next   = item.key_seed ^ challenge;
                    start_next = item.start_pos;
                    pos_next   = '0;
                end
                CMD_MSG:
                begin
                    if (scr)
                    begin
                        key_next = key_rolled;
                    end
                    if (pos_reg != {POS_W{1'b1}})
                    begin
                        pos_next = pos_reg + 1'b1;
                    end
                end
                default:
                begin
                    key_next = key_reg;
                end
            endcase
        end
    end

    // Load the result register, drop it once taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_scr_next   = out_scr_reg;
        if (take && is_msg)
        begin
            out_valid_next = 1'b1;
            out_byte_next  = scr ? (item.payload_byte ^ key_rolled) : item.payload_byte;
            out_scr_next   = scr;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg       <= 8'd0;
            pos_reg       <= '0;
            start_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            key_reg       <= key_next;
            pos_reg       <= pos_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_byte_reg <= out_byte_next;
        out_scr_reg  <= out_scr_next;
    end

    assign out_valid = out_valid_reg;
    assign out_byte  = out_byte_reg;
    assign out_scr   = out_scr_reg;

endmodule

/* hdl/rolling_key_xor_scrambler.sv */
// Top level of the rolling-key XOR scrambler: input register and wiring.
// Depends on kxs_pkg, kxs_apb_regs, kxs_text_store and kxs_key_unit.
//
// Channel   Direction  Contents
// s_*       in         tdata: text_addr, text_byte, key_seed, start_pos, payload_byte; tuser: cmd
// m_*       out        tdata: out_byte; tuser: was_scrambled
// APB       in/out     register 0 at byte address 0: challenge_key
//
// One transaction per cycle sustained while results are taken; an accepted byte passes
// the input register, then the result register. The text character for the next
// scrambled byte is prefetched from the text memory every cycle, so there is no
// read bubble. Reset clears control state only; the text memory needs no clearing.
// A message byte waits in the input register while the result register is full and
// not taken; text and header transactions pass it freely.
`timescale 1ns / 1ps

module rolling_key_xor_scrambler (
    input  logic                       clk,
    input  logic                       rst_n,
    // input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [47:0]                s_tdata,  // text_addr, text_byte, key_seed, start_pos, payload_byte
    input  logic [1:0]                 s_tuser,  // cmd
    // output stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,  // out_byte
    output logic                       m_tuser,  // was_scrambled
    // configuration
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [kxs_pkg::APB_AW-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);
    import kxs_pkg::*;

    logic       in_valid_reg;
    logic       in_valid_next;
    item_t      in_item_reg;
    item_t      in_item_next;
    item_t      s_item;
    logic       item_ready;
    logic       s_accept;
    logic [7:0] challenge;
    logic [7:0] cur_char;
    txt_ctl_t   ctl;

    // Unpack the input transaction
    always_comb
    begin
        s_item.cmd          = s_tuser;
        s_item.text_addr    = s_tdata[9:0];
        s_item.text_byte    = s_tdata[17:10];
        s_item.key_seed     = s_tdata[25:18];
        s_item.start_pos    = s_tdata[39:26];
        s_item.payload_byte = s_tdata[47:40];
    end

    // Input register: refill whenever the held transaction moves on
    assign s_tready = !in_valid_reg || item_ready;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        in_item_next  = in_item_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
            in_item_next  = s_item;
        end
        else if (item_ready)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_item_reg <= in_item_next;
    end

    kxs_apb_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .challenge (challenge)
    );

    kxs_text_store u_text (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctl      (ctl),
        .cur_char (cur_char)
    );

    kxs_key_unit u_key (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (in_valid_reg),
        .item       (in_item_reg),
        .item_ready (item_ready),
        .challenge  (challenge),
        .cur_char   (cur_char),
        .ctl        (ctl),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_byte   (m_tdata),
        .out_scr    (m_tuser)
    );

endmodule

/* sim/tb_rolling_key_xor_scrambler.sv */
// Self-checking testbench for the rolling-key XOR scrambler: a directed table and random
// phases, predicted by a shadow scrambler or typed per directed row, checked byte by byte.
// Depends on kxs_pkg and rolling_key_xor_scrambler.
`timescale 1ns / 1ps

module tb_rolling_key_xor_scrambler;

    import kxs_pkg::*;

    localparam logic [1:0]        CMD_NONE       = 2'd3;   // unused command code, ignored
    localparam logic [APB_AW-1:0] CHALLENGE_ADDR = APB_AW'(4 * REG_CHALLENGE);
    localparam int                QUIET_LIMIT    = 4000;
    localparam int                SINK_HOLD      = 300;
    localparam int                PHASE_ITEMS    = 95;
    localparam int                MAX_REPORTS    = 40;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       was_scrambled;
    } scr_result_t;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [TEXT_AW-1:0] addr;
        logic [7:0]         tbyte;
        logic [7:0]         seed;
        logic [POS_W-1:0]   spos;
        logic [7:0]         pay;
        logic               typed;
        logic [7:0]         t_out;
        logic               t_scr;
    } dir_row_t;

    // Directed rows; a typed expectation stands only where it is obvious
    localparam dir_row_t DIRECTED [22] = '{
        '{CMD_TEXT,  10'd0,     8'h41, 8'h00, 14'd0,      8'h00, 1'b0, 8'h00, 1'b0},
        '{CMD_TEXT,  10'd1,     8'h00, 8'h00, 14'd0,      8'h00, 1'b0, 8'h00, 1'b0},
        '{CMD_NONE,  10'h3FF,   8'hFF, 8'hFF, 14'h3FFF,   8'hFF, 1'b0, 8'h00, 1'b0},
        '{CMD_BEGIN, 10'd0,     8'h00, 8'h00, 14'd0,      8'h00, 1'b0, 8'h00, 1'b0},
        '{CMD_MSG,   10'd0,     8'h00, 8'h00, 14'd0,      8'h00, 1'b1, 8'h41, 1'b1},
        '{CMD_MSG,   10'd0,     8'h00, 8'h00, 14'd0,      8'hFF, 1'b1, 8'h3C, 1'b1},
        '{CMD_BEGIN, 10'd0,     8'h00, 8'hFF, 14'd2,      8'h00, 1'b0, 8'h00, 1'b0},
        '{CMD_MSG,   10'd0,     8'h00, 8'h00, 14'd0,      8'h5A, 1'b1, 8'h5A, 1'b0},
        '{CMD_MSG,   10'd0,     8'h00, 8'h00, 14'd0,      8'hA5, 1'b1, 8'hA5, 1'b0},
        '{CMD_MSG,   10'd0,     8'h00, 8'h00, 14'd0,      8'h00, 1'b0, 8'h00, 1'b0},
        '{CMD_TEXT,  10'd1,     8'h80, 8'h00, 14'd0,      8'h00, 1'b0, 8'h00, 1'b0},
        '{CMD_TEXT,  10'd2,     8'h25, 8'h00, 14'd0,      8'h00, 1'b0, 8'h00, 1'b0},
        '{CMD_TEXT,  10'd3,     8'h7F, 8'h00, 14'd0,      8'h00, 1'b0, 8'h00, 1'b0},
        '{CMD_TEXT,  10'd4,     8'h00, 8'h00, 14'd0,      8'h00, 1'b0, 8'h00, 1'b0},
        '{CMD_TEXT,  10'h3FF,   8'hFF, 8'h00, 14'd0,      8'h00, 1'b0, 8'h00, 1'b0},
        '{CMD_BEGIN, 10'd0,     8'h00, 8'hA5, 14'd0,      8'h00, 1'b0, 8'h00, 1'b0},
        '{CMD_MSG,   10'd0,     8'h00, 8'h00, 14'd0,      8'h3C, 1'b0, 8'h00, 1'b0},
        '{CMD_MSG,   10'd0,     8'h00, 8'h00, 14'd0,      8'hC3, 1'b0, 8'h00, 1'b0},
        '{CMD_MSG,   10'd0,     8'h00, 8'h00, 14'd0,      8'h0F, 1'b0, 8'h00, 1'b0},
        '{CMD_MSG,   10'd0,     8'h00, 8'h00, 14'd0,      8'hF0, 1'b0, 8'h00, 1'b0},
        '{CMD_MSG,   10'd0,     8'h00, 8'h00, 14'd0,      8'h81, 1'b0, 8'h00, 1'b0},
        '{CMD_NONE,  10'd0,     8'h00, 8'h00, 14'd0,      8'h00, 1'b0, 8'h00, 1'b0}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // text_addr, text_byte, key_seed, start_pos, payload_byte
    logic [1:0]  s_tuser;   // cmd
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // out_byte
    logic        m_tuser;   // was_scrambled
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_AW-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Shadow scrambler state
    logic [7:0]         shadow_text [TEXT_DEPTH];
    bit                 text_known  [TEXT_DEPTH];
    logic [TEXT_AW-1:0] fetch_idx;
    logic [7:0]         cur_key;
    logic [POS_W-1:0]   cur_pos;
    logic [POS_W-1:0]   first_pos;
    logic [7:0]         chal_key;

    scr_result_t expected_bytes [$];
    int          errors;
    int          results_seen;
    int          items_sent;
    int          quiet_cycles;
    bit          src_calm;

    rolling_key_xor_scrambler i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(4, 30);
    endfunction

    function automatic logic [7:0] text_char();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return CHAR_PERCENT;
        else if (r < 3)
            return 8'($urandom_range(128, 255));
        else
            return 8'($urandom_range(1, 127));
    endfunction

    function automatic item_t rand_item(input logic [1:0] cmd);
        item_t it;
        it              = '0;
        it.cmd          = cmd;
        it.text_addr    = TEXT_AW'($urandom);
        it.text_byte    = 8'($urandom);
        it.key_seed     = 8'($urandom);
        it.start_pos    = POS_W'($urandom);
        it.payload_byte = 8'($urandom);
        return it;
    endfunction

    // Advance the shadow scrambler by one transaction
    function automatic void scramble_predict(input item_t it, output bit has_out,
                                             output scr_result_t res);
        logic [7:0] ch;
        has_out = 1'b0;
        res     = '0;
        case (it.cmd)
            CMD_TEXT:
            begin
                shadow_text[it.text_addr] = it.text_byte;
                text_known[it.text_addr]  = 1'b1;
            end
            CMD_BEGIN:
            begin
                cur_key   = it.key_seed ^ chal_key;
                first_pos = it.start_pos;
                cur_pos   = '0;
                fetch_idx = '0;
            end
            CMD_MSG:
            begin
                has_out = 1'b1;
                if (cur_pos >= first_pos)
                begin
                    // a terminator rewinds the text to its first character
                    if (shadow_text[fetch_idx] == 8'h00)
                        fetch_idx = '0;
                    ch = shadow_text[fetch_idx];
                    if (ch > 8'd127 || ch == CHAR_PERCENT)
                        ch = CHAR_DOT;
                    fetch_idx         = fetch_idx + 1'b1;
                    cur_key           = cur_key ^ (ch << cur_pos[0]);
                    res.out_byte      = it.payload_byte ^ cur_key;
                    res.was_scrambled = 1'b1;
                end
                else
                begin
                    res.out_byte      = it.payload_byte;
                    res.was_scrambled = 1'b0;
                end
                // hold the position once it reaches the top
                if (cur_pos != '1)
                    cur_pos = cur_pos + 1'b1;
            end
            default: ;
        endcase
    endfunction

    // Offer one transaction after a random gap, none while calm, and wait until it is taken
    task automatic push_item(input item_t it, input bit typed = 1'b0,
                             input logic [7:0] t_out = '0, input bit t_scr = 1'b0);
        int          g;
        bit          has_out;
        scr_result_t res;
        g = src_calm ? 0 : gap_len();
        if (g > 0)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (g - 1) @(negedge clk);
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= it.cmd;
        s_tdata  <= {it.payload_byte, it.start_pos, it.key_seed, it.text_byte, it.text_addr};
        scramble_predict(it, has_out, res);
        if (has_out)
        begin
            if (typed)
            begin
                res.out_byte      = t_out;
                res.was_scrambled = t_scr;
            end
            expected_bytes.push_back(res);
        end
        if (it.cmd != CMD_NONE)
            items_sent++;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic push_text(input logic [TEXT_AW-1:0] addr, input logic [7:0] ch);
        item_t it;
        it           = rand_item(CMD_TEXT);
        it.text_addr = addr;
        it.text_byte = ch;
        push_item(it);
    endtask

    // Write a terminator at an empty next entry, or text at an empty entry 0 met by a rewind
    task automatic guard_text();
        bit done;
        done = 1'b0;
        while (!done)
        begin
            if (cur_pos < first_pos)
                done = 1'b1;
            else if (!text_known[fetch_idx])
                push_text(fetch_idx, 8'h00);
            else if (shadow_text[fetch_idx] == 8'h00 && !text_known[0])
                push_text('0, text_char());
            else
                done = 1'b1;
        end
    endtask

    task automatic push_byte(input logic [7:0] b);
        item_t it;
        it              = rand_item(CMD_MSG);
        it.payload_byte = b;
        guard_text();
        push_item(it);
    endtask

    task automatic push_begin(input logic [7:0] seed, input logic [POS_W-1:0] spos);
        item_t it;
        it           = rand_item(CMD_BEGIN);
        it.key_seed  = seed;
        it.start_pos = spos;
        push_item(it);
    endtask

    task automatic apb_xfer(input bit wr, input logic [31:0] wdata, output logic [31:0] rdata);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= CHALLENGE_ADDR;
        pwdata  <= wdata;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        rdata = prdata;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Write the challenge with junk above the low byte, then read it back
    task automatic write_challenge(input logic [7:0] val);
        logic [31:0] rd;
        apb_xfer(1'b1, {24'($urandom), val}, rd);
        chal_key = val;
        apb_xfer(1'b0, '0, rd);
        if (rd[7:0] !== val)
        begin
            errors++;
            $error("challenge_key: expected %h, got %h", val, rd[7:0]);
        end
    endtask

    // Drop valid and drain every result, then let the pipeline settle
    task automatic wait_idle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_bytes.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic random_phase(input int n_items);
        int    stop_at;
        int    r;
        int    len;
        item_t it;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            r = $urandom_range(0, 99);
            if (r < 10)
            begin
                // load a fresh text with its terminator
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 60) : $urandom_range(0, 24);
                for (int a = 0; a < len; a++)
                    push_text(TEXT_AW'(a), text_char());
                push_text(TEXT_AW'(len), 8'h00);
            end
            else if (r < 85)
            begin
                src_calm = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 99);
                if (r < 15)
                    push_begin(8'($urandom), '0);
                else if (r < 30)
                    push_begin(8'($urandom), POS_W'($urandom));
                else
                    push_begin(8'($urandom), POS_W'($urandom_range(0, 12)));
                len = $urandom_range(1, 48);
                repeat (len) push_byte(8'($urandom));
            end
            else if (r < 90)
                push_text(TEXT_AW'($urandom), ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
            else if (r < 95)
                push_item(rand_item(CMD_NONE));
            else
                repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
        end
        src_calm = 1'b0;
    endtask

    // Sink: random back-pressure, calm stretches, and one long hold-off
    initial
    begin : sink
        int stall_left;
        bit calm;
        bit long_done;
        stall_left = 0;
        calm       = 1'b0;
        long_done  = 1'b0;
        m_tready   = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!long_done && results_seen >= 150)
            begin
                long_done  = 1'b1;
                stall_left = SINK_HOLD;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && $urandom_range(0, 4) == 0)
                    stall_left = gap_len();
            end
            if ($urandom_range(0, 255) == 0)
                calm = !calm;
        end
    end

    // Compare each output transaction with the oldest expectation
    always @(posedge clk)
    begin : result_check
        scr_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (expected_bytes.size() == 0)
            begin
                errors++;
                if (errors <= MAX_REPORTS)
                    $error("unexpected result: out_byte %h, was_scrambled %b", m_tdata, m_tuser);
            end
            else
            begin
                want = expected_bytes.pop_front();
                if (m_tdata !== want.out_byte)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $error("out_byte: expected %h, got %h", want.out_byte, m_tdata);
                end
                if (m_tuser !== want.was_scrambled)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $error("was_scrambled: expected %b, got %b", want.was_scrambled, m_tuser);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles <= 0;
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin : stimulus
        item_t it;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        errors       = 0;
        results_seen = 0;
        items_sent   = 0;
        quiet_cycles = 0;
        src_calm     = 1'b0;
        fetch_idx    = '0;
        cur_key      = '0;
        cur_pos      = '0;
        first_pos    = '0;
        chal_key     = '0;
        foreach (text_known[i])
            text_known[i] = 1'b0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed table, run on the reset value of the challenge
        foreach (DIRECTED[i])
        begin
            it              = '0;
            it.cmd          = DIRECTED[i].cmd;
            it.text_addr    = DIRECTED[i].addr;
            it.text_byte    = DIRECTED[i].tbyte;
            it.key_seed     = DIRECTED[i].seed;
            it.start_pos    = DIRECTED[i].spos;
            it.payload_byte = DIRECTED[i].pay;
            push_item(it, DIRECTED[i].typed, DIRECTED[i].t_out, DIRECTED[i].t_scr);
        end

        // Random phases, each under its own challenge
        for (int p = 0; p < 5; p++)
        begin
            wait_idle();
            if (p == 0)
                write_challenge(8'hFF);
            else if (p == 1)
                write_challenge(8'h00);
            else
                write_challenge(8'($urandom));
            random_phase(PHASE_ITEMS);
        end

        wait_idle();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

/* filelist.f */
hdl/kxs_pkg.sv
hdl/kxs_apb_regs.sv
hdl/kxs_text_store.sv
hdl/kxs_key_unit.sv
hdl/rolling_key_xor_scrambler.sv
sim/tb_rolling_key_xor_scrambler.sv
